FILE: rtl/core/lpht_pkg.sv
// Shared types and constants for the linear probe hash table.
package lpht_pkg;

  // Operation codes carried in the request
  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_SET   = 2'd1,
    OP_UNSET = 2'd2
  } op_t;

  // Slot tags; code three never gets written and reads as empty
  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_LIVE  = 2'd1;
  localparam logic [1:0] TAG_TOMB  = 2'd2;

  // Configuration register indexes
  localparam logic [0:0] CFG_CAP_LOG2 = 1'b0;
  localparam logic [0:0] CFG_MAX_FILL = 1'b1;

  localparam int CFG_DATA_W = 11;

  // Configuration reset values and the used count ceiling
  localparam logic [3:0]  CAP_LOG2_RST = 4'd10;
  localparam logic [10:0] MAX_FILL_RST = 11'd768;
  localparam logic [10:0] USED_MAX     = 11'h7FF;

  // Request transaction
  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] key_word;
    logic [31:0] key_hash;
    logic [63:0] write_value;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic        found;
    logic [63:0] read_value;
    logic        is_new;
    logic        table_full;
  } rsp_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_COMMIT,
    ST_HOLD
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_step;
    logic load_item;
    logic probe_step;
    logic commit;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic probe_done;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/lpht_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lpht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/lpht_ctrl.sv
// Controller state machine: clearing pass, accept, probe, commit and response hand-off.
module lpht_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lpht_pkg::sts_t sts,
  output lpht_pkg::cmd_t cmd
);

  import lpht_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd.probe_step = 1'b1;
        if (sts.probe_done) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

FILE: rtl/core/lpht_dpath.sv
// Datapath: slot memories, probe tracking, commit decision and response register.
module lpht_dpath #(
  parameter int SLOTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [lpht_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  lpht_pkg::req_t                      req_data,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output lpht_pkg::rsp_t                      rsp_data,
  input  lpht_pkg::cmd_t                      cmd,
  output lpht_pkg::sts_t                      sts
);

  import lpht_pkg::*;

  localparam int AW     = $clog2(SLOTS);
  localparam int LG_MAX = $clog2(SLOTS + 1) - 1;

  // Configuration registers and the used count
  logic [3:0]  capacity_log2;
  logic [10:0] max_fill;
  logic [10:0] used_count;

  // Clearing pass address
  logic [AW-1:0] clr_addr;

  // Current transaction
  logic [1:0]  op_q;
  logic [63:0] key_q;
  logic [63:0] wval_q;

  // Probe tracking
  logic [AW-1:0] mask;
  logic [4:0]    lg_eff;
  logic [AW-1:0] probe_idx;
  logic [AW-1:0] next_idx;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] cnt;
  logic          hit;
  logic [AW-1:0] hit_slot;
  logic [63:0]   hit_value;
  logic          have_tomb;
  logic [AW-1:0] tomb_slot;
  logic          have_empty;
  logic [AW-1:0] empty_slot;

  // Memory read data
  logic [1:0]  tag_rd;
  logic [63:0] key_rd;
  logic [63:0] val_rd;
  logic        is_live;
  logic        is_tomb;
  logic        is_empty;
  logic        key_match;

  // Commit decision
  rsp_t          res;
  rsp_t          res_q;
  logic          wr_tag;
  logic          wr_key;
  logic          wr_val;
  logic [AW-1:0] wr_addr;
  logic [1:0]    wr_tag_val;
  logic          bump;

  // Memory write ports
  logic          tag_we;
  logic [AW-1:0] tag_waddr;
  logic [1:0]    tag_wdata;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_log2 <= CAP_LOG2_RST;
      max_fill      <= MAX_FILL_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CAP_LOG2) capacity_log2 <= cfg_data[3:0];
      if (cfg_index == CFG_MAX_FILL) max_fill <= cfg_data[10:0];
    end
  end

  // Active capacity mask: log2 clamped to one below, to the memory size above
  always_comb begin
    if (capacity_log2 == 4'd0) begin
      lg_eff = 5'd1;
    end else if ({1'b0, capacity_log2} > 5'(LG_MAX)) begin
      lg_eff = 5'(LG_MAX);
    end else begin
      lg_eff = {1'b0, capacity_log2};
    end
    for (int i = 0; i < AW; i++) begin
      mask[i] = (5'(i) < lg_eff);
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q   <= req_data.operation;
      key_q  <= req_data.key_word;
      wval_q <= req_data.write_value;
    end
  end

  // Read address: start slot on accept, then the next slot every probe cycle
  assign next_idx = (probe_idx + 1'b1) & mask;
  assign rd_addr  = cmd.load_item ? (req_data.key_hash[AW-1:0] & mask) : next_idx;

  // Examine the slot whose data just came back
  assign is_live   = (tag_rd == TAG_LIVE);
  assign is_tomb   = (tag_rd == TAG_TOMB);
  assign is_empty  = !is_live && !is_tomb;
  assign key_match = is_live && (key_rd == key_q);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      probe_idx  <= rd_addr;
      cnt        <= '0;
      hit        <= 1'b0;
      have_tomb  <= 1'b0;
      have_empty <= 1'b0;
    end else if (cmd.probe_step) begin
      probe_idx <= rd_addr;
      cnt       <= cnt + 1'b1;
      priority if (key_match) begin
        hit       <= 1'b1;
        hit_slot  <= probe_idx;
        hit_value <= val_rd;
      end else if (is_tomb && !have_tomb) begin
        have_tomb <= 1'b1;
        tomb_slot <= probe_idx;
      end else if (is_empty) begin
        have_empty <= 1'b1;
        empty_slot <= probe_idx;
      end else begin
      end
    end
  end

  // Commit decision from the probe outcome
  always_comb begin
    res        = '0;
    wr_tag     = 1'b0;
    wr_key     = 1'b0;
    wr_val     = 1'b0;
    wr_addr    = hit_slot;
    wr_tag_val = TAG_LIVE;
    bump       = 1'b0;
    unique case (op_q)
      OP_GET: begin
        res.found = hit;
        if (hit) res.read_value = hit_value;
      end
      OP_SET: begin
        priority if (hit) begin
          wr_val = 1'b1;
        end else if (have_tomb) begin
          wr_tag     = 1'b1;
          wr_key     = 1'b1;
          wr_val     = 1'b1;
          wr_addr    = tomb_slot;
          res.is_new = 1'b1;
        end else if (have_empty && (used_count < max_fill)) begin
          wr_tag     = 1'b1;
          wr_key     = 1'b1;
          wr_val     = 1'b1;
          wr_addr    = empty_slot;
          bump       = 1'b1;
          res.is_new = 1'b1;
        end else begin
          res.table_full = 1'b1;
        end
      end
      OP_UNSET: begin
        if (hit) begin
          wr_tag     = 1'b1;
          wr_tag_val = TAG_TOMB;
          res.found  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Used count, saturating, never shrinks
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (cmd.commit && bump && (used_count != USED_MAX)) begin
      used_count <= used_count + 11'd1;
    end
  end

  // Tag writes come from the clearing pass or a commit
  assign tag_we    = cmd.clear_step || (cmd.commit && wr_tag);
  assign tag_waddr = cmd.clear_step ? clr_addr : wr_addr;
  assign tag_wdata = cmd.clear_step ? TAG_EMPTY : wr_tag_val;

  lpht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (rd_addr),
    .rdata (tag_rd)
  );

  lpht_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (cmd.commit && wr_key),
    .waddr (wr_addr),
    .wdata (key_q),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  lpht_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_val_ram (
    .clk   (clk),
    .we    (cmd.commit && wr_val),
    .waddr (wr_addr),
    .wdata (wval_q),
    .raddr (rd_addr),
    .rdata (val_rd)
  );

  // Result held past the commit, since the used count moves then
  always_ff @(posedge clk) begin
    if (cmd.commit) res_q <= res;
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) rsp_data <= cmd.commit ? res : res_q;
  end

  // Status back to the controller
  assign sts.clear_last = (clr_addr == AW'(SLOTS - 1));
  assign sts.probe_done = key_match || is_empty || (cnt == mask);
  assign sts.out_free   = !rsp_valid || !rsp_stall;

endmodule

FILE: rtl/core/linear_probe_hash_table.sv
// Top level of the linear probe hash table: controller, datapath and checks.
//
// Requests (req_valid/req_stall/req_data) carry a get, set or unset of a
// 64-bit key with a caller-supplied 32-bit hash. Each request transaction
// yields exactly one response transaction (rsp_valid/rsp_stall/rsp_data).
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 capacity_log2, 1 max_fill) at the clock edge; write only while idle.
//
// Timing: one item at a time. After a request is accepted, the probe walk
// examines from 1 slot up to the active capacity; the slot memories return
// one slot per cycle. The commit state then loads the response register when
// it is free, and the next request is taken in the idle state that follows.
// A new request is taken while the previous response still waits.
//
// Reset: synchronous, active high. After reset a clearing pass marks every
// slot empty, one per cycle; req_stall stays high meanwhile.
// If the receiver stalls, the response holds; the next item then waits after
// its commit until the response register frees.
module linear_probe_hash_table #(
  parameter int SLOTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  lpht_pkg::req_t                  req_data,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output lpht_pkg::rsp_t                  rsp_data,
  input  logic                            cfg_we,
  input  logic [0:0]                      cfg_index,
  input  logic [lpht_pkg::CFG_DATA_W-1:0] cfg_data
);

  import lpht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpht_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Clearing pass blocks requests right after reset
  assert property (@(posedge clk) $past(rst) |-> req_stall)
    else $error("request accepted during clearing pass");

  // One item at a time: no second request right after one is taken
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while an item is in progress");

  // A response is never loaded over one the receiver is stalling
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(rsp_valid && rsp_stall))
    else $error("response overwritten while stalled");

  // A new response appears only after the controller hands one off
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.load_out))
    else $error("response valid without a hand-off");

endmodule

FILE: verif/tb_linear_probe_hash_table.sv
// Self-checking testbench for the linear probe hash table: directed and random get/set/unset and unknown-op traffic.
`timescale 1ns / 100ps

module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  localparam int SLOTS         = 1024;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 110;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  // Receiver stall patterns
  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_HEAVY    = 2;
  localparam int STALL_PERIODIC = 3;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req_data;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp_data;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  linear_probe_hash_table #(.SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data(rsp_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the slot store plus the queue of responses still owed
  class probe_scoreboard;
    logic [1:0]  tags   [SLOTS];
    logic [63:0] keys   [SLOTS];
    logic [63:0] values [SLOTS];
    int unsigned used_count;
    logic [3:0]  cap_log2;
    logic [10:0] max_fill;
    rsp_t        pending_responses[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned get_hits;
    int unsigned placed;
    int unsigned refused;
    int unsigned unset_hits;

    function new();
      foreach (tags[i]) tags[i] = TAG_EMPTY;
      used_count = 0;
      cap_log2   = CAP_LOG2_RST;
      max_fill   = MAX_FILL_RST;
      mismatches = 0;
      checked    = 0;
      get_hits   = 0;
      placed     = 0;
      refused    = 0;
      unset_hits = 0;
    endfunction

    function void write_reg(logic [0:0] index, logic [10:0] data);
      if (index == CFG_CAP_LOG2) begin
        cap_log2 = data[3:0];
      end else begin
        max_fill = data;
      end
    endfunction

    // log2 below one acts as one; oversize capacity halves down to SLOTS
    function int unsigned active_slots();
      int unsigned lg;
      int unsigned n;
      lg = (cap_log2 < 1) ? 1 : cap_log2;
      n = 1 << lg;
      while (n > SLOTS) n = n >> 1;
      return n;
    endfunction

    // Probe the shadow store, apply the operation, queue the response
    function void note_request(req_t r);
      rsp_t        e;
      int unsigned n_slots;
      int unsigned mask;
      int unsigned idx;
      int unsigned hit_at;
      int unsigned tomb_at;
      int unsigned empty_at;
      bit          hit;
      bit          have_tomb;
      bit          have_empty;
      e = '0;
      n_slots = active_slots();
      mask = n_slots - 1;
      idx = r.key_hash & mask;
      hit = 0;
      have_tomb = 0;
      have_empty = 0;
      hit_at = 0;
      tomb_at = 0;
      empty_at = 0;
      if (r.operation != OP_UNKNOWN) begin
        for (int n = 0; n < n_slots; n++) begin
          if (tags[idx] == TAG_LIVE) begin
            if (keys[idx] == r.key_word) begin
              hit = 1;
              hit_at = idx;
              break;
            end
          end else if (tags[idx] == TAG_TOMB) begin
            if (!have_tomb) begin
              have_tomb = 1;
              tomb_at = idx;
            end
          end else begin
            have_empty = 1;
            empty_at = idx;
            break;
          end
          idx = (idx + 1) & mask;
        end
      end
      case (r.operation)
        OP_GET: begin
          if (hit) begin
            e.found = 1'b1;
            e.read_value = values[hit_at];
            get_hits++;
          end
        end
        OP_SET: begin
          if (hit) begin
            values[hit_at] = r.write_value;
          end else if (have_tomb) begin
            tags[tomb_at] = TAG_LIVE;
            keys[tomb_at] = r.key_word;
            values[tomb_at] = r.write_value;
            e.is_new = 1'b1;
            placed++;
          end else if (have_empty && used_count < max_fill) begin
            tags[empty_at] = TAG_LIVE;
            keys[empty_at] = r.key_word;
            values[empty_at] = r.write_value;
            if (used_count < USED_MAX) used_count++;
            e.is_new = 1'b1;
            placed++;
          end else begin
            e.table_full = 1'b1;
            refused++;
          end
        end
        OP_UNSET: begin
          if (hit) begin
            tags[hit_at] = TAG_TOMB;
            e.found = 1'b1;
            unset_hits++;
          end
        end
        default: ;
      endcase
      pending_responses.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (pending_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: found=%0b read_value=%h is_new=%0b table_full=%0b",
                   got.found, got.read_value, got.is_new, got.table_full);
        return;
      end
      e = pending_responses.pop_front();
      checked++;
      if (got.found !== e.found || got.read_value !== e.read_value ||
          got.is_new !== e.is_new || got.table_full !== e.table_full) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on response %0d:", checked);
          $display("  expected found=%0b read_value=%h is_new=%0b table_full=%0b",
                   e.found, e.read_value, e.is_new, e.table_full);
          $display("  actual   found=%0b read_value=%h is_new=%0b table_full=%0b",
                   got.found, got.read_value, got.is_new, got.table_full);
        end
      end
    endfunction
  endclass

  probe_scoreboard sb;
  int  burst_left;
  bit  steady_sender;
  bit  hold_request;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Global watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Response side: check at the rising edge, pick the next stall at the falling edge
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int period;
    rsp_stall = 1'b0;
    mode = STALL_NONE;
    mode_left = 64;
    hold_left = 0;
    period = 3;
    forever begin
      @(posedge clk);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        hold_left = $urandom_range(150, 300);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
        mode_left = $urandom_range(32, 200);
        period = $urandom_range(2, 5);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE:  rsp_stall <= 1'b0;
          STALL_LIGHT: rsp_stall <= ($urandom_range(0, 9) < 3);
          STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
          default:     rsp_stall <= (mode_left % period == 0);
        endcase
      end
    end
  end

  function automatic req_t make_req(logic [1:0] op, logic [63:0] k, logic [31:0] h,
                                    logic [63:0] v);
    req_t r;
    r.operation = op;
    r.key_word = k;
    r.key_hash = h;
    r.write_value = v;
    return r;
  endfunction

  // Offer one transaction, with bursts and random gaps in between
  task automatic send_request(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_valid <= 1'b1;
    req_data <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
  endtask

  task automatic release_request();
    @(negedge clk);
    req_valid <= 1'b0;
    burst_left = 0;
  endtask

  // Wait out every owed response, with slack after the last one
  task automatic wait_for_responses();
    while (sb.pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] cap, input logic [10:0] fill);
    logic [10:0] cap_word;
    cap_word = {7'($urandom), cap};
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CAP_LOG2;
    cfg_data <= cap_word;
    sb.write_reg(CFG_CAP_LOG2, cap_word);
    @(negedge clk);
    cfg_index <= CFG_MAX_FILL;
    cfg_data <= fill;
    sb.write_reg(CFG_MAX_FILL, fill);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [3:0]  caps [PHASES];
    logic [63:0] pool_key[$];
    logic [31:0] pool_hash[$];
    logic [63:0] k;
    logic [31:0] h;
    logic [1:0]  op;
    int unsigned fill;
    int unsigned pool_size;
    int unsigned pick;

    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_CAP_LOG2;
    cfg_data = '0;
    burst_left = 0;
    steady_sender = 0;
    hold_request = 0;
    caps = '{4'd4, 4'd3, 4'd10, 4'd5, 4'd1, 4'd6, 4'd2, 4'd15, 4'd4, 4'd8, 4'd7, 4'd3};

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    // clearing pass holds the request side off
    do @(posedge clk); while (req_stall);

    // Two-slot table (log2 of zero acts as one), no fill limit
    set_config(4'd0, 11'd2047);
    send_request(make_req(OP_GET, 64'd0, 32'd0, '1));
    send_request(make_req(OP_SET, 64'd0, 32'd0, '1));
    send_request(make_req(OP_SET, '1, '1, 64'd0));
    send_request(make_req(OP_GET, 64'd0, '1, 64'd0));
    send_request(make_req(OP_GET, '1, 32'd0, 64'd0));
    // every slot live, no match: refused, and a get scans the whole table
    send_request(make_req(OP_SET, 64'd5, 32'd0, 64'd7));
    send_request(make_req(OP_GET, 64'd5, 32'd2, 64'd0));
    send_request(make_req(OP_SET, 64'd0, 32'd1, 64'h0123_4567_89AB_CDEF));
    send_request(make_req(OP_UNSET, '1, 32'd0, 64'd0));
    send_request(make_req(OP_UNSET, '1, 32'd0, 64'd0));
    send_request(make_req(OP_GET, '1, 32'd1, 64'd0));
    // tombstone reuse
    send_request(make_req(OP_SET, 64'd5, 32'd1, 64'hFEDC_BA98_7654_3210));
    send_request(make_req(OP_UNKNOWN, {$urandom, $urandom}, $urandom, {$urandom, $urandom}));
    send_request(make_req(OP_UNSET, 64'd0, 32'd0, 64'd0));
    release_request();
    wait_for_responses();

    // Oversize capacity and a zero fill limit: only reuse and overwrite succeed
    set_config(4'd15, 11'd0);
    send_request(make_req(OP_SET, 64'hA, 32'h0000_0200, 64'd1));
    send_request(make_req(OP_SET, 64'hA, 32'd0, 64'd2));
    send_request(make_req(OP_SET, 64'd5, 32'd1, 64'd3));
    send_request(make_req(OP_GET, 64'hA, 32'hFFFF_FC00, 64'd0));
    send_request(make_req(OP_UNSET, 64'd5, 32'd1, 64'd0));
    send_request(make_req(OP_GET, 64'd5, 32'd1, 64'd0));
    send_request(make_req(OP_UNKNOWN, '1, '1, '1));
    release_request();
    wait_for_responses();

    // Random phases: a key pool per phase, mostly consistent key/hash pairs
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0:       fill = 2047;
        1:       fill = $urandom_range(1, 1024);
        2:       fill = sb.used_count + $urandom_range(0, 6);
        default: fill = 1024;
      endcase
      if (phase == 4) fill = 1;
      if (fill > 2047) fill = 2047;
      set_config(caps[phase], 11'(fill));
      steady_sender = ($urandom_range(0, 3) == 0);

      pool_key.delete();
      pool_hash.delete();
      pool_size = 2 * sb.active_slots();
      if (pool_size > 40) pool_size = 40;
      for (int j = 0; j < pool_size; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0:       k = '0;
            1:       k = '1;
            default: k = 64'd1 << $urandom_range(0, 63);
          endcase
        end else begin
          k = {$urandom, $urandom};
        end
        h = $urandom;
        // cluster half the hashes near the bottom slots to build long chains
        if ($urandom_range(0, 1) == 1) h[9:0] = 10'($urandom_range(0, 15));
        pool_key.push_back(k);
        pool_hash.push_back(h);
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long receiver hold-off while requests keep coming
        if (i == 15 && (phase == 1 || phase == 6)) hold_request = 1;
        pick = $urandom_range(0, 99);
        if (pick < 40) op = OP_SET;
        else if (pick < 70) op = OP_GET;
        else if (pick < 93) op = OP_UNSET;
        else op = OP_UNKNOWN;
        pick = $urandom_range(0, pool_size - 1);
        if ($urandom_range(0, 99) < 85) begin
          k = pool_key[pick];
          h = pool_hash[pick];
        end else if ($urandom_range(0, 1) == 1) begin
          k = pool_key[pick];
          h = $urandom;
        end else begin
          k = {$urandom, $urandom};
          h = $urandom;
        end
        send_request(make_req(op, k, h, {$urandom, $urandom}));
      end
      release_request();
      wait_for_responses();
    end

    $display("covered %0d transactions over %0d configurations, capacities 2 to 1024",
             sb.checked, PHASES + 2);
    $display("get hits %0d, keys placed %0d, sets refused %0d, unset hits %0d, slots used %0d",
             sb.get_hits, sb.placed, sb.refused, sb.unset_hits, sb.used_count);
    if (sb.mismatches == 0 && sb.pending_responses.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
